>>> sv/scfe_pkg.sv
// Shared types and constants of the sum-checked frame encoder.
package scfe_pkg;

   localparam logic FUNC_BEGIN = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   localparam logic [7:0] START_BYTE = 8'h3a;
   localparam logic [7:0] CR_BYTE    = 8'h0d;
   localparam logic [7:0] LF_BYTE    = 8'h0a;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_COMPACT_FORMAT = 1'b1;

   localparam int BURST_MAX = 11;
   localparam int BURST_CW  = 4;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [BURST_CW-1:0]       count;
      logic                      end_flag;
      logic                      err_flag;
   } burst_type;

   typedef struct packed {
      logic        open;
      logic [9:0]  remaining;
      logic [15:0] sum;
      logic        compact;
   } frame_state_type;

endpackage

>>> sv/scfe_channels.sv
// Valid/ready channel interfaces for the request and response sides.
interface scfe_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] function_code;
   logic [9:0]  payload_length;
   logic [7:0]  data_byte;

   modport source (output valid, func, function_code, payload_length, data_byte,
                   input ready);
   modport sink   (input valid, func, function_code, payload_length, data_byte,
                   output ready);
endinterface

interface scfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;
   logic       error;

   modport source (output valid, out_byte, run_last, frame_end, error, input ready);
   modport sink   (input valid, out_byte, run_last, frame_end, error, output ready);
endinterface

>>> sv/scfe_build.sv
// Combinational burst builder: turns one request and the frame state into a byte burst.
module scfe_build
   import scfe_pkg::*;
#(
   parameter int MAX_PAYLOAD = 512
) (
   input  logic            func,
   input  logic [15:0]     function_code,
   input  logic [9:0]      payload_length,
   input  logic [7:0]      data_byte,
   input  logic [15:0]     device_address,
   input  logic            compact_format,
   input  frame_state_type state_cur,
   output frame_state_type state_nxt,
   output burst_type       burst
);

   localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

   logic [9:0]  len_sat;
   logic [15:0] begin_sum;
   logic [15:0] data_sum;
   logic [9:0]  rem_dec;

   always_comb begin
      if ({7'b0, payload_length} > MaxLen) begin
         len_sat = MaxLen[9:0];
      end else begin
         len_sat = payload_length;
      end
      if (compact_format) begin
         begin_sum = 16'(function_code + {6'b0, len_sat});
      end else begin
         begin_sum = 16'(device_address + function_code + {6'b0, len_sat});
      end
      data_sum = 16'(state_cur.sum + {8'b0, data_byte});
      rem_dec  = (state_cur.remaining != 10'd0) ? 10'(state_cur.remaining - 10'd1) : 10'd0;
   end

   always_comb begin
      state_nxt = state_cur;
      burst     = '0;
      if (func == FUNC_BEGIN) begin
         state_nxt.compact   = compact_format;
         state_nxt.sum       = begin_sum;
         state_nxt.open      = (len_sat != 10'd0);
         state_nxt.remaining = len_sat;
         burst.bytes[0]      = START_BYTE;
         if (compact_format) begin
            burst.bytes[1] = function_code[7:0];
            burst.bytes[2] = len_sat[7:0];
            burst.count    = 4'd3;
            if (len_sat == 10'd0) begin
               burst.bytes[3] = begin_sum[7:0];
               burst.bytes[4] = begin_sum[15:8];
               burst.count    = 4'd5;
               burst.end_flag = 1'b1;
            end
         end else begin
            burst.bytes[1] = device_address[7:0];
            burst.bytes[2] = device_address[15:8];
            burst.bytes[3] = function_code[7:0];
            burst.bytes[4] = function_code[15:8];
            burst.bytes[5] = len_sat[7:0];
            burst.bytes[6] = {6'b0, len_sat[9:8]};
            burst.count    = 4'd7;
            if (len_sat == 10'd0) begin
               burst.bytes[7]  = begin_sum[7:0];
               burst.bytes[8]  = begin_sum[15:8];
               burst.bytes[9]  = CR_BYTE;
               burst.bytes[10] = LF_BYTE;
               burst.count     = 4'd11;
               burst.end_flag  = 1'b1;
            end
         end
      end else if (!state_cur.open) begin
         // Payload byte with no frame open: a single error result.
         burst.count    = 4'd1;
         burst.err_flag = 1'b1;
      end else begin
         state_nxt.sum       = data_sum;
         state_nxt.remaining = rem_dec;
         burst.bytes[0]      = data_byte;
         burst.count         = 4'd1;
         if (rem_dec == 10'd0) begin
            state_nxt.open = 1'b0;
            burst.bytes[1] = data_sum[7:0];
            burst.bytes[2] = data_sum[15:8];
            burst.end_flag = 1'b1;
            if (state_cur.compact) begin
               burst.count = 4'd3;
            end else begin
               burst.bytes[3] = CR_BYTE;
               burst.bytes[4] = LF_BYTE;
               burst.count    = 4'd5;
            end
         end
      end
   end

endmodule

>>> sv/sum_checked_frame_encoder.sv
// Top level of the sum-checked frame encoder: input register, burst register, byte output.
//
// The encoder turns begin and payload requests into a framed byte stream. A begin
// request sends the 0x3a start byte and the header (address, function code and length,
// little-endian; the compact format sends only the low bytes of function and length),
// each payload request sends its byte, and the frame closes with a 16-bit wrapping sum,
// low byte first, followed by CR LF in the full format. Lengths above MAX_PAYLOAD are
// clamped, and the clamped value is what the header carries. Every response transfer
// moves one byte; a request yields one byte for a plain payload byte or an error and
// three to eleven bytes for a header or a frame-closing byte. The burst register sends
// the bytes of each request in order; an input register ahead of it takes the next
// request while the current burst drains, so payload bytes stream at one per cycle
// while the output accepts them. The last byte of each burst carries run_last, the
// last byte of a complete frame also carries frame_end, and a payload byte with no
// frame open yields a single zero byte with error set. Configuration writes are meant
// for idle periods and take effect on the next begin request.
module sum_checked_frame_encoder
   import scfe_pkg::*;
#(
   parameter int MAX_PAYLOAD = 512
) (
   input  logic        clock,
   input  logic        reset,
   scfe_req_if.sink    req_bus,
   scfe_rsp_if.source  rsp_bus,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   // Configuration registers.
   logic [15:0] dev_addr_ff, dev_addr_in;
   logic        compact_ff, compact_in;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic [15:0] in_code_ff;
   logic [9:0]  in_len_ff;
   logic [7:0]  in_data_ff;

   // Frame state and burst register.
   frame_state_type     state_ff, state_in, state_nxt;
   burst_type           burst_ff, burst_nxt;
   logic                burst_valid_ff, burst_valid_in;
   logic [BURST_CW-1:0] idx_ff, idx_in;

   logic req_xfer;
   logic rsp_xfer;
   logic last_byte;
   logic load;

   scfe_build #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_build (
      .func          (in_func_ff),
      .function_code (in_code_ff),
      .payload_length(in_len_ff),
      .data_byte     (in_data_ff),
      .device_address(dev_addr_ff),
      .compact_format(compact_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_nxt),
      .burst         (burst_nxt)
   );

   assign last_byte = (idx_ff == 4'(burst_ff.count - 4'd1));
   assign rsp_xfer  = rsp_bus.valid && rsp_bus.ready;
   // The burst register refills when it is empty or its last byte is leaving.
   assign load      = in_valid_ff && (!burst_valid_ff || (rsp_xfer && last_byte));
   assign req_bus.ready = !in_valid_ff || load;
   assign req_xfer  = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid     = burst_valid_ff;
   assign rsp_bus.out_byte  = burst_ff.bytes[idx_ff];
   assign rsp_bus.run_last  = last_byte;
   assign rsp_bus.frame_end = burst_ff.end_flag && last_byte;
   assign rsp_bus.error     = burst_ff.err_flag;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      compact_in  = compact_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_in = csr_write_data;
            CSR_COMPACT_FORMAT: compact_in  = csr_write_data[0];
            default: ;
         endcase
      end

      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      // The frame state advances exactly when a request moves into the burst register.
      state_in       = load ? state_nxt : state_ff;
      burst_valid_in = burst_valid_ff;
      idx_in         = idx_ff;
      if (load) begin
         burst_valid_in = 1'b1;
         idx_in         = '0;
      end else if (rsp_xfer) begin
         if (last_byte) begin
            burst_valid_in = 1'b0;
            idx_in         = '0;
         end else begin
            idx_in = 4'(idx_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= 16'd1;
         compact_ff     <= 1'b0;
         in_valid_ff    <= 1'b0;
         state_ff       <= '0;
         burst_valid_ff <= 1'b0;
         idx_ff         <= '0;
      end else begin
         dev_addr_ff    <= dev_addr_in;
         compact_ff     <= compact_in;
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         burst_valid_ff <= burst_valid_in;
         idx_ff         <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_bus.func;
         in_code_ff <= req_bus.function_code;
         in_len_ff  <= req_bus.payload_length;
         in_data_ff <= req_bus.data_byte;
      end
      if (load) begin
         burst_ff <= burst_nxt;
      end
   end

   // The byte pointer never runs past the end of the burst being sent.
   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      burst_valid_ff |-> (idx_ff < burst_ff.count))
      else $error("burst index beyond burst length");

   // An open frame always still expects payload bytes.
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff.open |-> (state_ff.remaining != 10'd0))
      else $error("frame open with no payload remaining");

   // Error results stand alone and never close a frame.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (burst_valid_ff && burst_ff.err_flag) |-> (burst_ff.count == 4'd1 && !burst_ff.end_flag))
      else $error("error burst longer than one byte");

   // The frame state only changes when a request enters the burst register.
   a_state_moves_on_load: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(state_ff))
      else $error("frame state changed without a load");

endmodule
